/* rtl/point_affine_transform_2d_assert.svh */
// assertion helpers used by the checker file
`ifndef POINT_AFFINE_TRANSFORM_2D_ASSERT_SVH
`define POINT_AFFINE_TRANSFORM_2D_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define PAT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pat assertion violated");

// property checked on every rising clock edge, reset included
`define PAT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pat assertion violated");

`endif

/* rtl/pat_pkg.sv */
package pat_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned REG_WIDTH   = 16;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned OP_WIDTH    = 2;

  // fraction bits of the fixed-point factors
  localparam int unsigned SCALE_FRAC = 8;
  localparam int unsigned TRIG_FRAC  = 14;

  localparam logic [REG_WIDTH-1:0] SHIFT_RST = 16'sd0;
  localparam logic [REG_WIDTH-1:0] PIVOT_RST = 16'sd0;
  localparam logic [REG_WIDTH-1:0] SCALE_RST = 16'sd256;
  localparam logic [REG_WIDTH-1:0] COS_RST   = 16'sd16384;
  localparam logic [REG_WIDTH-1:0] SIN_RST   = 16'sd0;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_TRANSLATE = 2'd0,
    OP_SCALE     = 2'd1,
    OP_ROTATE    = 2'd2,
    OP_COMBINED  = 2'd3
  } pat_op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHIFT_X = 3'd0,
    REG_SHIFT_Y = 3'd1,
    REG_PIVOT_X = 3'd2,
    REG_PIVOT_Y = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5,
    REG_COS     = 3'd6,
    REG_SIN     = 3'd7
  } pat_reg_e;

  typedef struct packed {
    pat_op_e op;
    logic    clip;
  } pat_ctrl_t;

endpackage

/* rtl/point_affine_transform_2d.sv */
// 2d affine transform of a point about a programmable pivot.
// s_axis carries one point per transaction: tuser selects translate, scale,
// rotate or scale-rotate-translate; tdata holds the x and y coordinates.
// m_axis returns the transformed point with a clip flag in tuser.
// shift, pivot, scale (q8.8) and cos/sin (q2.14) are written through the
// cfg port; the user must write them only while no transaction is in
// flight, the block itself does not enforce this. an accepted input passes
// through the scale pipe, the rotate pipe and the translate/output register.
// throughput is one point per clock while m_axis is not stalled; every
// stage carries its own valid bit, so a stalled m_axis only holds back
// stages that are full and bubbles still close up behind it. the last
// stage is the output register, and data held there stays stable until
// m_axis_tready takes it. reset empties the pipeline and loads identity
// settings (unit scale, cosine one, zero shift, pivot and sine).
module point_affine_transform_2d #(
  parameter int unsigned COORD_WIDTH = pat_pkg::COORD_WIDTH,
  localparam int unsigned TDATA_W    = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,   // point_x, point_y
  input  logic [pat_pkg::OP_WIDTH-1:0]    s_axis_tuser,   // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata,   // result_x, result_y
  output logic [0:0]                      m_axis_tuser,   // clipped
  input  logic                            cfg_we_i,
  input  logic [pat_pkg::REG_IDX_W-1:0]   cfg_addr_i,
  input  logic [pat_pkg::REG_WIDTH-1:0]   cfg_wdata_i
);

  localparam int unsigned RW = pat_pkg::REG_WIDTH;

  logic signed [RW-1:0] shift_x_q, shift_y_q, pivot_x_q, pivot_y_q;
  logic signed [RW-1:0] scale_x_q, scale_y_q, cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q <= pat_pkg::SHIFT_RST;
      shift_y_q <= pat_pkg::SHIFT_RST;
      pivot_x_q <= pat_pkg::PIVOT_RST;
      pivot_y_q <= pat_pkg::PIVOT_RST;
      scale_x_q <= pat_pkg::SCALE_RST;
      scale_y_q <= pat_pkg::SCALE_RST;
      cos_q     <= pat_pkg::COS_RST;
      sin_q     <= pat_pkg::SIN_RST;
    end else if (cfg_we_i) begin
      unique case (pat_pkg::pat_reg_e'(cfg_addr_i))
        pat_pkg::REG_SHIFT_X: shift_x_q <= cfg_wdata_i;
        pat_pkg::REG_SHIFT_Y: shift_y_q <= cfg_wdata_i;
        pat_pkg::REG_PIVOT_X: pivot_x_q <= cfg_wdata_i;
        pat_pkg::REG_PIVOT_Y: pivot_y_q <= cfg_wdata_i;
        pat_pkg::REG_SCALE_X: scale_x_q <= cfg_wdata_i;
        pat_pkg::REG_SCALE_Y: scale_y_q <= cfg_wdata_i;
        pat_pkg::REG_COS:     cos_q     <= cfg_wdata_i;
        pat_pkg::REG_SIN:     sin_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pat_pkg::pat_ctrl_t     in_ctrl, sc_ctrl, rot_ctrl;
  logic                   sc_valid, sc_ready, rot_valid, rot_ready;
  logic [COORD_WIDTH-1:0] sc_x, sc_y, rot_x, rot_y, out_x, out_y;
  logic                   out_clip;

  assign in_ctrl.op   = pat_pkg::pat_op_e'(s_axis_tuser);
  assign in_ctrl.clip = 1'b0;

  pat_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .ctrl_i    (in_ctrl),
    .x_i       (s_axis_tdata[COORD_WIDTH-1:0]),
    .y_i       (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pivot_x_i (pivot_x_q),
    .pivot_y_i (pivot_y_q),
    .scale_x_i (scale_x_q),
    .scale_y_i (scale_y_q),
    .valid_o   (sc_valid),
    .ready_i   (sc_ready),
    .ctrl_o    (sc_ctrl),
    .x_o       (sc_x),
    .y_o       (sc_y)
  );

  pat_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sc_valid),
    .ready_o   (sc_ready),
    .ctrl_i    (sc_ctrl),
    .x_i       (sc_x),
    .y_i       (sc_y),
    .pivot_x_i (pivot_x_q),
    .pivot_y_i (pivot_y_q),
    .cos_i     (cos_q),
    .sin_i     (sin_q),
    .valid_o   (rot_valid),
    .ready_i   (rot_ready),
    .ctrl_o    (rot_ctrl),
    .x_o       (rot_x),
    .y_o       (rot_y)
  );

  pat_translate #(.COORD_WIDTH(COORD_WIDTH)) u_translate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rot_valid),
    .ready_o   (rot_ready),
    .ctrl_i    (rot_ctrl),
    .x_i       (rot_x),
    .y_i       (rot_y),
    .shift_x_i (shift_x_q),
    .shift_y_i (shift_y_q),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .clip_o    (out_clip),
    .x_o       (out_x),
    .y_o       (out_y)
  );

  assign m_axis_tdata    = TDATA_W'({out_y, out_x});
  assign m_axis_tuser[0] = out_clip;

endmodule

/* rtl/pat_scale.sv */
module pat_scale #(
  parameter int unsigned COORD_WIDTH = pat_pkg::COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  pat_pkg::pat_ctrl_t                   ctrl_i,
  input  logic [COORD_WIDTH-1:0]               x_i,
  input  logic [COORD_WIDTH-1:0]               y_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] pivot_x_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] pivot_y_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] scale_x_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] scale_y_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output pat_pkg::pat_ctrl_t                   ctrl_o,
  output logic [COORD_WIDTH-1:0]               x_o,
  output logic [COORD_WIDTH-1:0]               y_o
);

  localparam int unsigned RW = pat_pkg::REG_WIDTH;
  localparam int unsigned DW = ((COORD_WIDTH > RW) ? COORD_WIDTH : RW) + 1;
  localparam int unsigned PW = DW + RW;
  localparam int unsigned QW = PW - pat_pkg::SCALE_FRAC;
  localparam int unsigned SW = QW + 1;
  localparam int unsigned NS = 4;

  function automatic logic [COORD_WIDTH:0] sat(input logic [SW-1:0] v);
    logic                   ovf;
    logic [COORD_WIDTH-1:0] r;
    ovf = !((&v[SW-1:COORD_WIDTH-1]) || !(|v[SW-1:COORD_WIDTH-1]));
    if (ovf) begin
      r = v[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return {ovf, r};
  endfunction

  logic [NS-1:0] vld_q, adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (adv & {vld_q[NS-2:0], valid_i}) | (~adv & vld_q);
    end
  end

  // stage 0: offset from pivot
  pat_pkg::pat_ctrl_t       ctrl0_q, ctrl1_q, ctrl2_q, ctrl3_q;
  logic [COORD_WIDTH-1:0]   x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic signed [DW-1:0]     dx_d, dy_d, dx_q, dy_q;
  logic signed [PW-1:0]     px_d, py_d, px_q, py_q;
  logic [PW-1:0]            bx, by;
  logic signed [QW-1:0]     qx_q, qy_q;
  logic [SW-1:0]            sx, sy;
  logic [COORD_WIDTH:0]     satx, saty;
  logic                     active;

  always_comb begin
    dx_d = {{(DW-COORD_WIDTH){x_i[COORD_WIDTH-1]}}, x_i}
         - {{(DW-RW){pivot_x_i[RW-1]}}, pivot_x_i};
    dy_d = {{(DW-COORD_WIDTH){y_i[COORD_WIDTH-1]}}, y_i}
         - {{(DW-RW){pivot_y_i[RW-1]}}, pivot_y_i};
    px_d = dx_q * scale_x_i;
    py_d = dy_q * scale_y_i;
    // bias negative products so the shift truncates toward zero
    bx = px_q + {{(PW-pat_pkg::SCALE_FRAC){1'b0}}, {pat_pkg::SCALE_FRAC{px_q[PW-1]}}};
    by = py_q + {{(PW-pat_pkg::SCALE_FRAC){1'b0}}, {pat_pkg::SCALE_FRAC{py_q[PW-1]}}};
    sx = {qx_q[QW-1], qx_q} + {{(SW-RW){pivot_x_i[RW-1]}}, pivot_x_i};
    sy = {qy_q[QW-1], qy_q} + {{(SW-RW){pivot_y_i[RW-1]}}, pivot_y_i};
    satx = sat(sx);
    saty = sat(sy);
    active = (ctrl2_q.op == pat_pkg::OP_SCALE) || (ctrl2_q.op == pat_pkg::OP_COMBINED);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ctrl0_q <= ctrl_i;
      x0_q    <= x_i;
      y0_q    <= y_i;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
    end
    if (adv[1]) begin
      ctrl1_q <= ctrl0_q;
      x1_q    <= x0_q;
      y1_q    <= y0_q;
      px_q    <= px_d;
      py_q    <= py_d;
    end
    if (adv[2]) begin
      ctrl2_q <= ctrl1_q;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      qx_q    <= bx[PW-1:pat_pkg::SCALE_FRAC];
      qy_q    <= by[PW-1:pat_pkg::SCALE_FRAC];
    end
    if (adv[3]) begin
      ctrl3_q.op   <= ctrl2_q.op;
      ctrl3_q.clip <= ctrl2_q.clip | (active & (satx[COORD_WIDTH] | saty[COORD_WIDTH]));
      x3_q         <= active ? satx[COORD_WIDTH-1:0] : x2_q;
      y3_q         <= active ? saty[COORD_WIDTH-1:0] : y2_q;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[NS-1];
  assign ctrl_o  = ctrl3_q;
  assign x_o     = x3_q;
  assign y_o     = y3_q;

endmodule

/* rtl/pat_rotate.sv */
module pat_rotate #(
  parameter int unsigned COORD_WIDTH = pat_pkg::COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  pat_pkg::pat_ctrl_t                   ctrl_i,
  input  logic [COORD_WIDTH-1:0]               x_i,
  input  logic [COORD_WIDTH-1:0]               y_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] pivot_x_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] pivot_y_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] cos_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] sin_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output pat_pkg::pat_ctrl_t                   ctrl_o,
  output logic [COORD_WIDTH-1:0]               x_o,
  output logic [COORD_WIDTH-1:0]               y_o
);

  localparam int unsigned RW = pat_pkg::REG_WIDTH;
  localparam int unsigned DW = ((COORD_WIDTH > RW) ? COORD_WIDTH : RW) + 1;
  localparam int unsigned PW = DW + RW;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned QW = AW - pat_pkg::TRIG_FRAC;
  localparam int unsigned SW = QW + 1;
  localparam int unsigned NS = 5;

  function automatic logic [COORD_WIDTH:0] sat(input logic [SW-1:0] v);
    logic                   ovf;
    logic [COORD_WIDTH-1:0] r;
    ovf = !((&v[SW-1:COORD_WIDTH-1]) || !(|v[SW-1:COORD_WIDTH-1]));
    if (ovf) begin
      r = v[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return {ovf, r};
  endfunction

  logic [NS-1:0] vld_q, adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (adv & {vld_q[NS-2:0], valid_i}) | (~adv & vld_q);
    end
  end

  pat_pkg::pat_ctrl_t     ctrl0_q, ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q;
  logic [COORD_WIDTH-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [DW-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic signed [PW-1:0]   xc_d, ys_d, xs_d, yc_d, xc_q, ys_q, xs_q, yc_q;
  logic [AW-1:0]          rx_d, ry_d, rx_q, ry_q, bx, by;
  logic [QW-1:0]          qx_q, qy_q;
  logic [SW-1:0]          sx, sy;
  logic [COORD_WIDTH:0]   satx, saty;
  logic                   active;

  always_comb begin
    dx_d = {{(DW-COORD_WIDTH){x_i[COORD_WIDTH-1]}}, x_i}
         - {{(DW-RW){pivot_x_i[RW-1]}}, pivot_x_i};
    dy_d = {{(DW-COORD_WIDTH){y_i[COORD_WIDTH-1]}}, y_i}
         - {{(DW-RW){pivot_y_i[RW-1]}}, pivot_y_i};
    xc_d = dx_q * cos_i;
    ys_d = dy_q * sin_i;
    xs_d = dx_q * sin_i;
    yc_d = dy_q * cos_i;
    rx_d = {xc_q[PW-1], xc_q} - {ys_q[PW-1], ys_q};
    ry_d = {xs_q[PW-1], xs_q} + {yc_q[PW-1], yc_q};
    // bias negative sums so the shift truncates toward zero
    bx = rx_q + {{(AW-pat_pkg::TRIG_FRAC){1'b0}}, {pat_pkg::TRIG_FRAC{rx_q[AW-1]}}};
    by = ry_q + {{(AW-pat_pkg::TRIG_FRAC){1'b0}}, {pat_pkg::TRIG_FRAC{ry_q[AW-1]}}};
    sx = {qx_q[QW-1], qx_q} + {{(SW-RW){pivot_x_i[RW-1]}}, pivot_x_i};
    sy = {qy_q[QW-1], qy_q} + {{(SW-RW){pivot_y_i[RW-1]}}, pivot_y_i};
    satx = sat(sx);
    saty = sat(sy);
    active = (ctrl3_q.op == pat_pkg::OP_ROTATE) || (ctrl3_q.op == pat_pkg::OP_COMBINED);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ctrl0_q <= ctrl_i;
      x0_q    <= x_i;
      y0_q    <= y_i;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
    end
    if (adv[1]) begin
      ctrl1_q <= ctrl0_q;
      x1_q    <= x0_q;
      y1_q    <= y0_q;
      xc_q    <= xc_d;
      ys_q    <= ys_d;
      xs_q    <= xs_d;
      yc_q    <= yc_d;
    end
    if (adv[2]) begin
      ctrl2_q <= ctrl1_q;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
    end
    if (adv[3]) begin
      ctrl3_q <= ctrl2_q;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      qx_q    <= bx[AW-1:pat_pkg::TRIG_FRAC];
      qy_q    <= by[AW-1:pat_pkg::TRIG_FRAC];
    end
    if (adv[4]) begin
      ctrl4_q.op   <= ctrl3_q.op;
      ctrl4_q.clip <= ctrl3_q.clip | (active & (satx[COORD_WIDTH] | saty[COORD_WIDTH]));
      x4_q         <= active ? satx[COORD_WIDTH-1:0] : x3_q;
      y4_q         <= active ? saty[COORD_WIDTH-1:0] : y3_q;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[NS-1];
  assign ctrl_o  = ctrl4_q;
  assign x_o     = x4_q;
  assign y_o     = y4_q;

endmodule

/* rtl/pat_translate.sv */
module pat_translate #(
  parameter int unsigned COORD_WIDTH = pat_pkg::COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  pat_pkg::pat_ctrl_t                   ctrl_i,
  input  logic [COORD_WIDTH-1:0]               x_i,
  input  logic [COORD_WIDTH-1:0]               y_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] shift_x_i,
  input  logic signed [pat_pkg::REG_WIDTH-1:0] shift_y_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic                                 clip_o,
  output logic [COORD_WIDTH-1:0]               x_o,
  output logic [COORD_WIDTH-1:0]               y_o
);

  localparam int unsigned RW = pat_pkg::REG_WIDTH;
  localparam int unsigned SW = ((COORD_WIDTH > RW) ? COORD_WIDTH : RW) + 1;

  function automatic logic [COORD_WIDTH:0] sat(input logic [SW-1:0] v);
    logic                   ovf;
    logic [COORD_WIDTH-1:0] r;
    ovf = !((&v[SW-1:COORD_WIDTH-1]) || !(|v[SW-1:COORD_WIDTH-1]));
    if (ovf) begin
      r = v[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return {ovf, r};
  endfunction

  logic                   vld_q, adv;
  logic                   clip_q;
  logic [COORD_WIDTH-1:0] x_q, y_q;
  logic [SW-1:0]          sx, sy;
  logic [COORD_WIDTH:0]   satx, saty;
  logic                   active;

  // this stage doubles as the output register
  assign adv = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= valid_i;
    end
  end

  always_comb begin
    sx = {{(SW-COORD_WIDTH){x_i[COORD_WIDTH-1]}}, x_i}
       + {{(SW-RW){shift_x_i[RW-1]}}, shift_x_i};
    sy = {{(SW-COORD_WIDTH){y_i[COORD_WIDTH-1]}}, y_i}
       + {{(SW-RW){shift_y_i[RW-1]}}, shift_y_i};
    satx = sat(sx);
    saty = sat(sy);
    active = (ctrl_i.op == pat_pkg::OP_TRANSLATE) || (ctrl_i.op == pat_pkg::OP_COMBINED);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_q <= ctrl_i.clip | (active & (satx[COORD_WIDTH] | saty[COORD_WIDTH]));
      x_q    <= active ? satx[COORD_WIDTH-1:0] : x_i;
      y_q    <= active ? saty[COORD_WIDTH-1:0] : y_i;
    end
  end

  assign ready_o = adv;
  assign valid_o = vld_q;
  assign clip_o  = clip_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

/* rtl/pat_checker.sv */
`include "point_affine_transform_2d_assert.svh"

module pat_checker #(
  parameter int unsigned COORD_WIDTH = pat_pkg::COORD_WIDTH,
  localparam int unsigned TDATA_W    = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  // a transaction waiting on the output keeps its payload
  `PAT_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // with the output register empty nothing can back up the pipe
  `PAT_ASSERT(a_ready_when_drained, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)

  // an edge seen in reset leaves the pipeline empty
  `PAT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid)

  // first edge after reset cannot show a result yet
  `PAT_ASSERT(a_no_result_after_reset, clk_i, rst_ni, !$past(rst_ni) |-> !m_axis_tvalid)

endmodule

bind point_affine_transform_2d pat_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
